// ===== src/sdel_pkg.sv =====
`timescale 1ns / 1ps

package sdel_pkg;

   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned PLEN_W      = 4;
   localparam int unsigned PAT_W       = 64;
   localparam int unsigned KW          = 3;   // index of a pattern character
   localparam int unsigned MAX_PATTERN = 8;
   localparam int unsigned CSR_DW      = 64;
   localparam int unsigned CSR_AW      = 4;

   // register index, taken from paddr[3]
   localparam logic REG_PATTERN_LEN   = 1'b0;
   localparam logic REG_PATTERN_BYTES = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_TEST,
      ST_CMP,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMPTY
   } st_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] out_char;
      logic              out_last;
      logic              found;
      logic              empty_res;
      logic              overflow;
   } rsp_type;

   // pattern lengths above the supported maximum saturate
   function automatic logic [PLEN_W-1:0] sat_plen(input logic [PLEN_W-1:0] len);
      logic [PLEN_W-1:0] lim;
      lim = PLEN_W'(MAX_PATTERN);
      sat_plen = (len > lim) ? lim : len;
   endfunction

endpackage

// ===== src/substring_delete_all.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// --------  --------------------------------------  -------------------------------
// request   req_text_char, req_text_last            start & !busy takes a beat
// result    rsp_out_char, rsp_out_last, rsp_found,  rsp_valid, one cycle per beat
//           rsp_empty_res, rsp_overflow
// config    psel, penable, pwrite, paddr, pwdata,   APB, write at access phase,
//           prdata, pready                          pready tied high
//
// Sequence: a non-final character is taken and busy stays low. The final beat
// starts the edit pass on the buffer (one read port, one write port): at each
// scan position, up to plen compare steps (read, then compare one byte), then
// each kept character is copied (read, then write); a tail character where the
// pattern no longer fits gets a test, then the copy. Then each result beat is
// emitted (read, then output), with a single beat for an empty result.
// Reset: synchronous, active high; no clearing pass, only buffer data below
// the loaded count. The receiver cannot stall; busy holds off new requests
// until the final result beat has been issued.

module substring_delete_all
   import sdel_pkg::*;
#(
   parameter int unsigned MAX_TEXT = 64   // buffer depth, 8..64
) (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              start,
   output logic              busy,
   input  logic [CHAR_W-1:0] req_text_char,
   input  logic              req_text_last,
   // result
   output logic              rsp_valid,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_out_last,
   output logic              rsp_found,
   output logic              rsp_empty_res,
   output logic              rsp_overflow,
   // config
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int unsigned AW = $clog2(MAX_TEXT);
   localparam int unsigned CW = $clog2(MAX_TEXT + 1);

   // config registers
   logic [PLEN_W-1:0] plen_ff,    plen_in;
   logic [PAT_W-1:0]  pattern_ff, pattern_in;
   logic              csr_wr;

   // buffer port
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [CHAR_W-1:0] mem_rdata;
   rsp_type           rsp;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   // bits [2:0] are byte lanes within a 64-bit register; paddr[3] picks it
   always_comb begin
      plen_in    = plen_ff;
      pattern_in = pattern_ff;
      if (csr_wr) begin
         case (paddr[3])
            REG_PATTERN_LEN:   plen_in    = pwdata[PLEN_W-1:0];
            REG_PATTERN_BYTES: pattern_in = pwdata;
            default: begin
               plen_in = plen_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3])
         REG_PATTERN_LEN:   prdata = CSR_DW'(plen_ff);
         REG_PATTERN_BYTES: prdata = pattern_ff;
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff    <= PLEN_W'(1);
         pattern_ff <= '0;
      end else begin
         plen_ff    <= plen_in;
         pattern_ff <= pattern_in;
      end
   end

   sdel_mem #(
      .DEPTH (MAX_TEXT),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // sequencer: load, scan with one byte comparator, compact in place, emit
   sdel_ctrl #(
      .MAX_TEXT (MAX_TEXT),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .text_char (req_text_char),
      .text_last (req_text_last),
      .plen      (sat_plen(plen_ff)),
      .pattern   (pattern_ff),
      .busy      (busy),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .rsp       (rsp)
   );

   // result beat straight from the sequencer's output register
   assign rsp_valid     = rsp.valid;
   assign rsp_out_char  = rsp.out_char;
   assign rsp_out_last  = rsp.out_last;
   assign rsp_found     = rsp.found;
   assign rsp_empty_res = rsp.empty_res;
   assign rsp_overflow  = rsp.overflow;

endmodule

// ===== src/sdel_mem.sv =====
`timescale 1ns / 1ps

module sdel_mem
   import sdel_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [CHAR_W-1:0] wdata,
   input  logic [AW-1:0]     raddr,
   output logic [CHAR_W-1:0] rdata
);

   logic [CHAR_W-1:0] mem_ff [DEPTH];
   logic [CHAR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/sdel_ctrl.sv =====
`timescale 1ns / 1ps

module sdel_ctrl
   import sdel_pkg::*;
#(
   parameter int unsigned MAX_TEXT = 64,
   parameter int unsigned AW       = 6,
   parameter int unsigned CW       = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CHAR_W-1:0] text_char,
   input  logic              text_last,
   input  logic [PLEN_W-1:0] plen,
   input  logic [PAT_W-1:0]  pattern,
   output logic              busy,
   output logic              mem_we,
   output logic [AW-1:0]     mem_waddr,
   output logic [CHAR_W-1:0] mem_wdata,
   output logic [AW-1:0]     mem_raddr,
   input  logic [CHAR_W-1:0] mem_rdata,
   output rsp_type           rsp
);

   st_type          state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;   // characters loaded
   logic            drop_ff,  drop_in;
   logic            found_ff, found_in;
   logic [CW-1:0]   rd_ff,    rd_in;      // read position / emit index
   logic [CW-1:0]   wr_ff,    wr_in;      // compacted length
   logic [KW-1:0]   k_ff,     k_in;
   rsp_type         rsp_ff,   rsp_in;

   logic            fit;
   logic [CW-1:0]   rd_skip;
   logic [CW-1:0]   rd_k;
   logic [CHAR_W-1:0] pat_char;

   assign fit      = (plen != '0) &&
                     (({1'b0, rd_ff} + (CW+1)'(plen)) <= {1'b0, count_ff});
   assign rd_skip  = rd_ff + CW'(plen);
   assign rd_k     = rd_ff + CW'(k_ff);
   assign pat_char = pattern[{k_ff, 3'b000} +: CHAR_W];
   assign busy     = (state_ff != ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         found_ff <= 1'b0;
         rd_ff    <= '0;
         wr_ff    <= '0;
         k_ff     <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         found_ff <= found_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         k_ff     <= k_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      found_in  = found_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      k_in      = k_ff;
      rsp_in    = '0;
      rsp_in.found    = found_ff;
      rsp_in.overflow = drop_ff;
      mem_we    = 1'b0;
      mem_waddr = wr_ff[AW-1:0];
      mem_wdata = mem_rdata;
      mem_raddr = rd_ff[AW-1:0];

      case (state_ff)
         ST_LOAD: begin
            mem_waddr = count_ff[AW-1:0];
            mem_wdata = text_char;
            if (start) begin
               if (count_ff < CW'(MAX_TEXT)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (text_last) begin
                  state_in = ST_TEST;
                  rd_in    = '0;
                  wr_in    = '0;
                  k_in     = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_TEST: begin
            mem_raddr = rd_k[AW-1:0];
            if (fit) begin
               state_in = ST_CMP;
            end else if (rd_ff < count_ff) begin
               state_in = ST_COPY_RD;
            end else begin
               rd_in    = '0;
               state_in = (wr_ff == '0) ? ST_EMPTY : ST_EMIT_RD;
            end
         end
         ST_CMP: begin
            if (mem_rdata != pat_char) begin
               k_in     = '0;
               state_in = ST_COPY_RD;
            end else if (({1'b0, k_ff} + 1'b1) == plen) begin
               // full match: drop it, the next char is kept untested
               found_in = 1'b1;
               k_in     = '0;
               rd_in    = rd_skip;
               state_in = (rd_skip < count_ff) ? ST_COPY_RD : ST_TEST;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            mem_we   = 1'b1;
            wr_in    = wr_ff + 1'b1;
            rd_in    = rd_ff + 1'b1;
            state_in = ST_TEST;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_in.valid    = 1'b1;
            rsp_in.out_char = mem_rdata;
            rsp_in.out_last = ((rd_ff + 1'b1) == wr_ff);
            rd_in           = rd_ff + 1'b1;
            if ((rd_ff + 1'b1) == wr_ff) begin
               count_in = '0;
               drop_in  = 1'b0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMPTY: begin
            rsp_in.valid     = 1'b1;
            rsp_in.out_last  = 1'b1;
            rsp_in.empty_res = 1'b1;
            count_in = '0;
            drop_in  = 1'b0;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp = rsp_ff;

`ifndef NO_ASSERTIONS
   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_TEST) || (state_ff == ST_CMP) ||
       (state_ff == ST_COPY_RD) || (state_ff == ST_COPY_WR)) |-> (wr_ff <= rd_ff))
      else $error("compaction write pointer passed read pointer");

   a_rd_in_text: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST || state_ff == ST_CMP) |-> (rd_ff <= count_ff))
      else $error("scan position beyond loaded text");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TEXT))
      else $error("text count above buffer size");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && rsp_ff.empty_res) |-> rsp_ff.out_last)
      else $error("empty result without last mark");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && rsp_ff.out_last) |-> (count_ff == '0 && !drop_ff))
      else $error("run state not cleared after final beat");
`endif

endmodule
